// ----- rtl/core/imu_serial_frame_parser_core_assert.svh -----
// Assertion macros for the IMU serial frame parser checker.
// No dependencies; expects clk_i and rst_ni in the using scope.
`ifndef IMU_SERIAL_FRAME_PARSER_CORE_ASSERT_SVH
`define IMU_SERIAL_FRAME_PARSER_CORE_ASSERT_SVH

// Checked on every rising edge, skipped while reset is applied.
`define IMUSFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same check, with a disable condition of the caller's choosing.
`define IMUSFP_ASSERT_IF(label, dis, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (dis) (prop)) else $error(msg);

`endif

// ----- rtl/core/imusfp_pkg.sv -----
// Shared constants and result type for the IMU serial frame parser.
// No dependencies.
`timescale 1ns / 1ps

package imusfp_pkg;

  localparam int unsigned FRAME_LENGTH = 11;
  localparam int unsigned STORE_DEPTH  = FRAME_LENGTH - 1;
  localparam int unsigned POS_W        = 4;

  localparam logic [POS_W-1:0] LAST_POS    = POS_W'(FRAME_LENGTH - 1);
  localparam logic [7:0]       HEADER_BYTE = 8'h55;
  localparam logic [7:0]       TYPE_FIRST  = 8'h50;
  localparam logic [7:0]       TYPE_LAST   = 8'h58;

  typedef struct packed {
    logic [7:0]         frame_type;
    logic               known_type;
    logic signed [15:0] word_0;
    logic signed [15:0] word_1;
    logic signed [15:0] word_2;
    logic signed [15:0] word_3;
    logic signed [31:0] long_low_half;
    logic signed [31:0] long_high_half;
    logic [31:0]        frames_seen;
    logic [31:0]        bytes_skipped;
  } imusfp_result_t;

endpackage

// ----- rtl/core/imu_serial_frame_parser_core.sv -----
// Top level of the IMU serial frame parser: byte assembler plus output register.
// Depends on imusfp_pkg, imusfp_assembler, imusfp_out_stage.
//
//   channel | dir | signals                          | handshake
//   rx byte | in  | rx_byte_i                        | in_valid_i / in_ready_o
//   frame   | out | frame_type_o .. bytes_skipped_o  | out_valid_o / out_ready_i
//
// One byte per cycle is accepted while in_ready_o is high; a frame's last byte passes
// through the input register and the per-byte update logic into the output register.
// Reset clears frame position, both counters and the valid flags; the byte store is not reset.
// A stalled result holds back only the final byte of the next frame; other bytes keep flowing.
`timescale 1ns / 1ps

module imu_serial_frame_parser_core import imusfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         frame_type_o,
  output logic               known_type_o,
  output logic signed [15:0] word_0_o,
  output logic signed [15:0] word_1_o,
  output logic signed [15:0] word_2_o,
  output logic signed [15:0] word_3_o,
  output logic signed [31:0] long_low_half_o,
  output logic signed [31:0] long_high_half_o,
  output logic [31:0]        frames_seen_o,
  output logic [31:0]        bytes_skipped_o
);

  logic           res_valid, out_free;
  imusfp_result_t res, out_res;

  imusfp_assembler u_assembler (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  imusfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_res)
  );

  assign frame_type_o     = out_res.frame_type;
  assign known_type_o     = out_res.known_type;
  assign word_0_o         = out_res.word_0;
  assign word_1_o         = out_res.word_1;
  assign word_2_o         = out_res.word_2;
  assign word_3_o         = out_res.word_3;
  assign long_low_half_o  = out_res.long_low_half;
  assign long_high_half_o = out_res.long_high_half;
  assign frames_seen_o    = out_res.frames_seen;
  assign bytes_skipped_o  = out_res.bytes_skipped;

endmodule

// ----- rtl/core/imusfp_assembler.sv -----
// Input register, frame position, byte store and counters; builds one result per frame.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

module imusfp_assembler import imusfp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           out_free_i,
  output logic           res_valid_o,
  output imusfp_result_t res_o
);

  logic             in_vld_q;
  logic [7:0]       byte_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [31:0]      frame_cnt_q, frame_cnt_d;
  logic [31:0]      skip_cnt_q, skip_cnt_d;
  logic [7:0]       store_q [1:STORE_DEPTH-1];
  logic             is_final, hdr_miss, advance;

  assign is_final   = (pos_q >= LAST_POS);
  assign hdr_miss   = (pos_q == '0) && (byte_q != HEADER_BYTE);
  assign advance    = in_vld_q && (!is_final || out_free_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  always_comb begin
    pos_d       = pos_q;
    frame_cnt_d = frame_cnt_q;
    skip_cnt_d  = skip_cnt_q;
    if (advance) begin
      if (hdr_miss) begin
        skip_cnt_d = skip_cnt_q + 32'd1;
      end else if (!is_final) begin
        pos_d = pos_q + POS_W'(1);
      end else begin
        pos_d       = '0;
        frame_cnt_d = frame_cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      frame_cnt_q <= '0;
      skip_cnt_q  <= '0;
    end else begin
      pos_q       <= pos_d;
      frame_cnt_q <= frame_cnt_d;
      skip_cnt_q  <= skip_cnt_d;
    end
  end

  // Header byte is known, so only bytes 1..9 are kept.
  always_ff @(posedge clk_i) begin
    for (int i = 1; i < STORE_DEPTH; i++) begin
      if (advance && !is_final && (pos_q == POS_W'(i))) begin
        store_q[i] <= byte_q;
      end
    end
  end

  assign res_valid_o = in_vld_q && is_final && out_free_i;

  always_comb begin
    res_o.frame_type     = store_q[1];
    res_o.known_type     = store_q[1] inside {[TYPE_FIRST:TYPE_LAST]};
    res_o.word_0         = {store_q[3], store_q[2]};
    res_o.word_1         = {store_q[5], store_q[4]};
    res_o.word_2         = {store_q[7], store_q[6]};
    res_o.word_3         = {store_q[9], store_q[8]};
    res_o.long_low_half  = {store_q[2], store_q[3], store_q[4], store_q[5]};
    res_o.long_high_half = {store_q[6], store_q[7], store_q[8], store_q[9]};
    res_o.frames_seen    = frame_cnt_q + 32'd1;
    res_o.bytes_skipped  = skip_cnt_q;
  end

endmodule

// ----- rtl/core/imusfp_out_stage.sv -----
// Output register holding one finished frame result until it is taken.
// Depends on imusfp_pkg.
`timescale 1ns / 1ps

module imusfp_out_stage import imusfp_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  imusfp_result_t res_i,
  output logic           out_free_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output imusfp_result_t out_o
);

  logic           vld_q;
  imusfp_result_t res_q;

  assign out_free_o  = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (out_free_o) begin
      vld_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i && out_free_o) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- rtl/core/imusfp_port_checker.sv -----
// Port-level checks for the IMU serial frame parser, bound to the top level.
// Depends on imusfp_pkg and imu_serial_frame_parser_core_assert.svh.
`timescale 1ns / 1ps

`include "imu_serial_frame_parser_core_assert.svh"

module imusfp_port_checker import imusfp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [7:0]         frame_type_o,
  input logic               known_type_o,
  input logic signed [15:0] word_0_o,
  input logic signed [15:0] word_1_o,
  input logic [31:0]        frames_seen_o,
  input logic signed [31:0] long_low_half_o
);

  logic [31:0] taken_q;

  // Count of results taken so far.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      taken_q <= taken_q + 32'd1;
    end
  end

  `IMUSFP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(frames_seen_o), "stalled request dropped or changed")
  `IMUSFP_ASSERT(a_frame_seq, out_valid_o |-> frames_seen_o == taken_q + 32'd1, "frame request lost or repeated")
  `IMUSFP_ASSERT(a_known_type, out_valid_o |-> known_type_o == ((frame_type_o >= TYPE_FIRST) && (frame_type_o <= TYPE_LAST)), "known_type flag mismatch")
  `IMUSFP_ASSERT_IF(a_long_words, !rst_ni || !out_valid_o, long_low_half_o == {word_0_o[7:0], word_0_o[15:8], word_1_o[7:0], word_1_o[15:8]}, "long word disagrees with 16-bit words")

endmodule

bind imu_serial_frame_parser_core imusfp_port_checker u_port_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .frame_type_o    (frame_type_o),
  .known_type_o    (known_type_o),
  .word_0_o        (word_0_o),
  .word_1_o        (word_1_o),
  .frames_seen_o   (frames_seen_o),
  .long_low_half_o (long_low_half_o)
);
